/* rtl/fpda_pkg.sv */
// ----------------------------------------------------------------------------
// fpda_pkg
// Shared types and constants for the 16.16 fixed-point to decimal text
// converter: channel payloads, controller states and command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package fpda_pkg;

	// digit buffer layout: integer digits, then fraction digits
	localparam int INT_DIGITS      = 5;
	localparam int MAX_FRAC_DIGITS = 6;
	localparam int NUM_DIGITS      = INT_DIGITS + MAX_FRAC_DIGITS;
	localparam int CONV_STEPS      = (INT_DIGITS > MAX_FRAC_DIGITS) ? INT_DIGITS
		: MAX_FRAC_DIGITS;
	localparam int MSEC_SHIFT      = 3;

	// point position and strip limit for each mode
	localparam logic [3:0] PT_NORM    = 4'(INT_DIGITS);
	localparam logic [3:0] PT_MSEC    = 4'(INT_DIGITS + MSEC_SHIFT);
	localparam logic [3:0] LIMIT_NORM = 4'(INT_DIGITS - 1);
	localparam logic [3:0] LIMIT_MSEC = 4'(INT_DIGITS + MSEC_SHIFT - 1);

	// reciprocal of ten for 16-bit operands: x / 10 = (x * 0xcccd) >> 19
	localparam logic [15:0] DIV10_MUL = 16'hcccd;
	localparam int          DIV10_SHR = 19;

	// prefix select codes
	localparam logic [1:0] PFX_NONE  = 2'd0;
	localparam logic [1:0] PFX_MINUS = 2'd1;
	localparam logic [1:0] PFX_PLUS  = 2'd2;

	// character codes (ascii, six bits)
	localparam logic [5:0] CH_PLUS  = 6'd43;
	localparam logic [5:0] CH_MINUS = 6'd45;
	localparam logic [5:0] CH_DOT   = 6'd46;
	localparam logic [5:0] CH_ZERO  = 6'd48;

	typedef struct packed {
		logic [31:0] value;
		logic        is_signed;
		logic [1:0]  sign_prefix;
		logic [2:0]  decimals;
		logic        msec_mode;
	} in_item_t;

	typedef struct packed {
		logic [5:0] char_code;
		logic       last_char;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_ROUND,
		ST_STRIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic conv;
		logic round;
		logic strip;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic round_done;
		logic out_free;
		logic emit_last;
	} status_t;

endpackage

`default_nettype wire

/* rtl/fixed_point_to_decimal_ascii.sv */
// Sequence: after a request is taken, the six-step digit conversion, the
//   rounding carry walk (no carry steps when no round-up is needed) and the
//   zero strip run, then one character per cycle while out_ready is high. A new
//   number is accepted only once the last character of the previous one is registered.
// Reset: arst_n clears the controller and the output valid flag at once.
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_ascii
// Converts a 16.16 fixed-point word to decimal ascii text, one character per
// output transfer, with a flag on the final character.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_to_decimal_ascii (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire fpda_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output fpda_pkg::out_item_t     out_data
);

	fpda_pkg::cmd_t    cmd;
	fpda_pkg::status_t status;

	// sequencer
	fpda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// conversion datapath
	fpda_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* rtl/fpda_ctrl.sv */
// ----------------------------------------------------------------------------
// fpda_ctrl
// Sequencer: load, digit conversion, rounding, zero strip, character output.
// ----------------------------------------------------------------------------
`default_nettype none

module fpda_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire fpda_pkg::status_t status,
	output fpda_pkg::cmd_t       cmd
);

	fpda_pkg::state_t state_q;
	fpda_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fpda_pkg::ST_IDLE: begin
				if (in_valid) state_d = fpda_pkg::ST_CONV;
			end
			fpda_pkg::ST_CONV: begin
				if (status.conv_done) state_d = fpda_pkg::ST_ROUND;
			end
			fpda_pkg::ST_ROUND: begin
				if (status.round_done) state_d = fpda_pkg::ST_STRIP;
			end
			fpda_pkg::ST_STRIP: begin
				state_d = fpda_pkg::ST_EMIT;
			end
			fpda_pkg::ST_EMIT: begin
				if (status.out_free && status.emit_last) state_d = fpda_pkg::ST_IDLE;
			end
			default: begin
				state_d = fpda_pkg::ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			fpda_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			fpda_pkg::ST_CONV:  cmd.conv  = 1'b1;
			fpda_pkg::ST_ROUND: cmd.round = 1'b1;
			fpda_pkg::ST_STRIP: cmd.strip = 1'b1;
			fpda_pkg::ST_EMIT:  cmd.emit  = 1'b1;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_load_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == fpda_pkg::ST_CONV))
		else $error("accepted request did not start conversion");

	a_conv_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fpda_pkg::ST_CONV && !status.conv_done)
		|=> (state_q == fpda_pkg::ST_CONV))
		else $error("conversion left before all digits were produced");

	a_emit_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fpda_pkg::ST_EMIT && !status.out_free)
		|=> (state_q == fpda_pkg::ST_EMIT))
		else $error("emit left while output register was full");
`endif

endmodule

`default_nettype wire

/* rtl/fpda_dpath.sv */
// ----------------------------------------------------------------------------
// fpda_dpath
// Digit buffer, divide-by-ten and times-ten units, rounding carry walk,
// leading zero search and the output character register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpda_dpath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fpda_pkg::in_item_t in_data,
	input  wire fpda_pkg::cmd_t     cmd,
	output fpda_pkg::status_t       status,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output fpda_pkg::out_item_t     out_data
);

	logic [15:0] ipart_q;
	logic [15:0] frac_q;
	logic [2:0]  nfrac_q;
	logic        msec_q;
	logic [2:0]  cnt_q;
	logic [3:0]  dig_q [fpda_pkg::NUM_DIGITS];
	logic [3:0]  ptr_q;
	logic [3:0]  last_q;
	logic        carry_q;
	logic        sign_pend_q;
	logic [5:0]  sign_char_q;
	logic        dot_done_q;
	logic        out_valid_q;
	fpda_pkg::out_item_t out_q;

	logic [31:0] mag;
	logic        has_sign;
	logic [5:0]  sign_char;
	logic [3:0]  nfrac_sum;
	logic [2:0]  nfrac;
	logic [31:0] div_prod;
	logic [12:0] quot;
	logic [15:0] quot_x10;
	logic [15:0] rem;
	logic [19:0] frac_prod;
	logic [15:0] frac_d;
	logic        int_step;
	logic        frac_step;
	logic [3:0]  int_idx;
	logic [3:0]  frac_idx;
	logic [3:0]  dig_rd;
	logic [3:0]  limit;
	logic [3:0]  start;
	logic [3:0]  pt;
	logic        dot_now;
	logic [5:0]  ch;
	logic        ch_last;
	logic        out_free;

	// magnitude, prefix and fraction digit count of a new request
	always_comb begin
		mag       = in_data.value;
		has_sign  = 1'b0;
		sign_char = fpda_pkg::CH_MINUS;
		if (in_data.is_signed) begin
			if (in_data.value[31]) begin
				mag      = 32'd0 - in_data.value;
				has_sign = 1'b1;
			end
		end else if (in_data.sign_prefix == fpda_pkg::PFX_MINUS) begin
			has_sign = 1'b1;
		end else if (in_data.sign_prefix == fpda_pkg::PFX_PLUS) begin
			has_sign  = 1'b1;
			sign_char = fpda_pkg::CH_PLUS;
		end
		if (in_data.msec_mode) begin
			nfrac_sum = {1'b0, in_data.decimals} + 4'(fpda_pkg::MSEC_SHIFT);
		end else begin
			nfrac_sum = {1'b0, in_data.decimals};
		end
		if (nfrac_sum > 4'(fpda_pkg::MAX_FRAC_DIGITS)) begin
			nfrac = 3'(fpda_pkg::MAX_FRAC_DIGITS);
		end else begin
			nfrac = nfrac_sum[2:0];
		end
	end

	// at most one integer digit (divide by ten) and at most one fraction digit (times ten) per step
	always_comb begin
		div_prod  = {16'd0, ipart_q} * {16'd0, fpda_pkg::DIV10_MUL};
		quot      = div_prod[31:fpda_pkg::DIV10_SHR];
		quot_x10  = {quot, 3'b000} + {2'b00, quot, 1'b0};
		rem       = ipart_q - quot_x10;
		frac_prod = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};
		int_step  = ({1'b0, cnt_q} < 4'(fpda_pkg::INT_DIGITS));
		frac_step = (cnt_q < nfrac_q);
		frac_d    = frac_step ? frac_prod[15:0] : frac_q;
		int_idx   = 4'(fpda_pkg::INT_DIGITS - 1) - {1'b0, cnt_q};
		frac_idx  = 4'(fpda_pkg::INT_DIGITS) + {1'b0, cnt_q};
	end

	// shared digit read port: carry walk and character output
	assign dig_rd = dig_q[ptr_q];

	// first nonzero digit before the strip limit, or the limit itself
	always_comb begin
		limit = msec_q ? fpda_pkg::LIMIT_MSEC : fpda_pkg::LIMIT_NORM;
		start = limit;
		for (int i = int'(fpda_pkg::LIMIT_MSEC) - 1; i >= 0; i--) begin
			if (4'(i) < limit && dig_q[i] != 4'd0) start = 4'(i);
		end
	end

	// next character
	always_comb begin
		pt      = msec_q ? fpda_pkg::PT_MSEC : fpda_pkg::PT_NORM;
		dot_now = (ptr_q == pt) && !dot_done_q;
		if (sign_pend_q) begin
			ch      = sign_char_q;
			ch_last = 1'b0;
		end else if (dot_now) begin
			ch      = fpda_pkg::CH_DOT;
			ch_last = 1'b0;
		end else begin
			ch      = fpda_pkg::CH_ZERO + {2'b00, dig_rd};
			ch_last = (ptr_q == last_q);
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// work registers and digit buffer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ipart_q     <= mag[31:16];
			frac_q      <= mag[15:0];
			nfrac_q     <= nfrac;
			msec_q      <= in_data.msec_mode;
			cnt_q       <= 3'd0;
			last_q      <= 4'(fpda_pkg::INT_DIGITS - 1) + {1'b0, nfrac};
			sign_pend_q <= has_sign;
			sign_char_q <= sign_char;
		end
		if (cmd.conv) begin
			cnt_q <= cnt_q + 3'd1;
			if (int_step) begin
				dig_q[int_idx] <= rem[3:0];
				ipart_q        <= {3'b000, quot};
			end
			if (frac_step) begin
				dig_q[frac_idx] <= frac_prod[19:16];
			end
			frac_q <= frac_d;
			if (status.conv_done) begin
				carry_q <= frac_d[15];
				ptr_q   <= last_q;
			end
		end
		if (cmd.round && carry_q) begin
			if (dig_rd == 4'd9 && ptr_q != 4'd0) begin
				dig_q[ptr_q] <= 4'd0;
				ptr_q        <= ptr_q - 4'd1;
			end else begin
				dig_q[ptr_q] <= dig_rd + 4'd1;
				carry_q      <= 1'b0;
			end
		end
		if (cmd.strip) begin
			ptr_q      <= start;
			dot_done_q <= 1'b0;
		end
		if (cmd.emit && out_free) begin
			out_q <= '{char_code: ch, last_char: ch_last};
			if (sign_pend_q) begin
				sign_pend_q <= 1'b0;
			end else if (dot_now) begin
				dot_done_q <= 1'b1;
			end else begin
				ptr_q <= ptr_q + 4'd1;
			end
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign status.conv_done  = (cnt_q == 3'(fpda_pkg::CONV_STEPS - 1));
	assign status.round_done = !carry_q;
	assign status.out_free   = out_free;
	assign status.emit_last  = ch_last;

`ifndef SYNTHESIS
	a_digit_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !sign_pend_q && !dot_now) |-> (dig_rd <= 4'd9))
		else $error("emitted digit out of decimal range");

	a_start_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.strip |=> (ptr_q <= last_q))
		else $error("first digit lies past the last digit");

	a_carry_settles: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.round && carry_q && dig_rd != 4'd9) |=> !carry_q)
		else $error("rounding carry not absorbed by a digit below nine");
`endif

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives 16.16 fixed-point requests into the decimal text converter and checks
// every output character and its last flag against a local digit predictor.
// Directed numbers cover the edges; random numbers follow under three
// back-pressure patterns on the request and character channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	// prefix code with no character of its own
	localparam logic [1:0] PFX_UNUSED = 2'd3;
	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 40;
	localparam int LIMIT_CYCLES = 200000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	fpda_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	fpda_pkg::out_item_t out_data;

	int                  send_idle_pct;
	int                  recv_idle_pct;
	int                  error_count;
	fpda_pkg::out_item_t pending_chars [$];

	fixed_point_to_decimal_ascii i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// run limit
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("testbench failed");
		$finish;
	end

	// expected text of one number, appended to the pending characters
	function automatic void predict_text(input fpda_pkg::in_item_t req);
		logic [31:0] mag;
		logic [31:0] frac;
		logic [15:0] ipart;
		logic [3:0]  digits [0:fpda_pkg::NUM_DIGITS-1];
		logic [5:0]  sign_ch;
		logic [5:0]  chars [$];
		fpda_pkg::out_item_t ch;
		bit          has_sign;
		int          nfrac;
		int          stop;
		int          pt;
		int          lim;
		int          first;
		int          pos;

		has_sign = 1'b0;
		sign_ch  = fpda_pkg::CH_MINUS;
		mag      = req.value;
		if (req.is_signed) begin
			if (req.value[31]) begin
				mag      = -req.value;
				has_sign = 1'b1;
			end
		end else begin
			case (req.sign_prefix)
				fpda_pkg::PFX_MINUS: begin
					has_sign = 1'b1;
				end
				fpda_pkg::PFX_PLUS: begin
					has_sign = 1'b1;
					sign_ch  = fpda_pkg::CH_PLUS;
				end
				default: begin
					has_sign = 1'b0;
				end
			endcase
		end

		// integer digits by repeated division
		for (pos = 0; pos < fpda_pkg::NUM_DIGITS; pos++)
			digits[pos] = 4'd0;
		ipart = mag[31:16];
		for (pos = fpda_pkg::INT_DIGITS - 1; pos >= 0; pos--) begin
			digits[pos] = 4'(ipart % 16'd10);
			ipart       = ipart / 16'd10;
		end

		// fraction digit count and point position
		if (req.msec_mode) begin
			nfrac = int'(req.decimals) + fpda_pkg::MSEC_SHIFT;
			pt    = fpda_pkg::INT_DIGITS + fpda_pkg::MSEC_SHIFT;
		end else begin
			nfrac = int'(req.decimals);
			pt    = fpda_pkg::INT_DIGITS;
		end
		if (nfrac > fpda_pkg::MAX_FRAC_DIGITS)
			nfrac = fpda_pkg::MAX_FRAC_DIGITS;

		// fraction digits by repeated multiplication
		frac = mag;
		for (pos = 0; pos < nfrac; pos++) begin
			frac                               = {16'h0, frac[15:0]} * 32'd10;
			digits[fpda_pkg::INT_DIGITS + pos] = 4'(frac >> 16);
		end
		stop = fpda_pkg::INT_DIGITS + nfrac;

		// round half up, carry may ripple into the leading digit
		if (frac[15]) begin
			pos = stop - 1;
			digits[pos]++;
			while (digits[pos] >= 4'd10 && pos > 0) begin
				digits[pos] = 4'd0;
				pos--;
				digits[pos]++;
			end
		end

		// strip leading zeros, keeping the digit before the point
		lim = pt - 1;
		if (lim > stop - 1)
			lim = stop - 1;
		first = 0;
		while (first < lim && digits[first] == 4'd0)
			first++;

		if (has_sign)
			chars.push_back(sign_ch);
		for (pos = first; pos < stop; pos++) begin
			if (pos == pt)
				chars.push_back(fpda_pkg::CH_DOT);
			chars.push_back(fpda_pkg::CH_ZERO + 6'(digits[pos]));
		end

		foreach (chars[idx]) begin
			ch.char_code = chars[idx];
			ch.last_char = (idx == chars.size() - 1);
			pending_chars.push_back(ch);
		end
	endfunction

	function automatic fpda_pkg::in_item_t make_request(input logic [31:0] value,
			input logic is_signed, input logic [1:0] sign_prefix, input logic [2:0] decimals,
			input logic msec_mode);
		fpda_pkg::in_item_t req;

		req.value       = value;
		req.is_signed   = is_signed;
		req.sign_prefix = sign_prefix;
		req.decimals    = decimals;
		req.msec_mode   = msec_mode;
		return req;
	endfunction

	// send one request, with a random gap before it
	task automatic send_request(input fpda_pkg::in_item_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do
			@(posedge clk);
		while (!in_ready);
		predict_text(req);
	endtask

	// character sink with random stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// compare each accepted character with the oldest pending one
	always @(posedge clk) begin : check_chars
		fpda_pkg::out_item_t want;

		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected character: char_code %0d last_char %0d",
					out_data.char_code, out_data.last_char);
				error_count++;
			end else begin
				want = pending_chars.pop_front();
				if (out_data.char_code !== want.char_code) begin
					$error("char_code: expected %0d, actual %0d",
						want.char_code, out_data.char_code);
					error_count++;
				end
				if (out_data.last_char !== want.last_char) begin
					$error("last_char: expected %0d, actual %0d",
						want.last_char, out_data.last_char);
					error_count++;
				end
			end
		end
	end

	// zero, all ones, most negative and tiny magnitudes
	task automatic test_extremes();
		send_request(make_request(32'h0000_0000, 1'b0, fpda_pkg::PFX_NONE,  3'd0, 1'b0));
		send_request(make_request(32'hffff_ffff, 1'b0, fpda_pkg::PFX_PLUS,  3'd6, 1'b0));
		send_request(make_request(32'h8000_0000, 1'b1, fpda_pkg::PFX_NONE,  3'd3, 1'b0));
		send_request(make_request(32'hffff_ffff, 1'b1, fpda_pkg::PFX_PLUS,  3'd6, 1'b0));
		send_request(make_request(32'h7fff_ffff, 1'b1, fpda_pkg::PFX_MINUS, 3'd0, 1'b0));
		send_request(make_request(32'h0000_0001, 1'b0, fpda_pkg::PFX_NONE,  3'd7, 1'b0));
		send_request(make_request(32'hffff_ffff, 1'b0, fpda_pkg::PFX_NONE,  3'd7, 1'b1));
	endtask

	// prefix codes minus, plus and unused on the unsigned path, plus and minus on the signed path
	task automatic test_sign_prefix();
		send_request(make_request(32'h0003_4000, 1'b0, fpda_pkg::PFX_MINUS, 3'd2, 1'b0));
		send_request(make_request(32'h0003_4000, 1'b0, fpda_pkg::PFX_PLUS,  3'd2, 1'b0));
		send_request(make_request(32'h0003_4000, 1'b0, PFX_UNUSED,          3'd2, 1'b0));
		send_request(make_request(32'hfffc_c000, 1'b1, fpda_pkg::PFX_PLUS,  3'd2, 1'b0));
		send_request(make_request(32'h0003_4000, 1'b1, fpda_pkg::PFX_MINUS, 3'd2, 1'b0));
	endtask

	// half-up rounding and carry past the leading digit
	task automatic test_rounding();
		send_request(make_request(32'h0009_f5c3, 1'b0, fpda_pkg::PFX_NONE, 3'd1, 1'b0));
		send_request(make_request(32'h0000_8000, 1'b0, fpda_pkg::PFX_NONE, 3'd0, 1'b0));
		send_request(make_request(32'h0000_7fff, 1'b0, fpda_pkg::PFX_NONE, 3'd0, 1'b0));
		send_request(make_request(32'h0000_ffff, 1'b0, fpda_pkg::PFX_NONE, 3'd0, 1'b0));
		send_request(make_request(32'h0063_fff0, 1'b0, fpda_pkg::PFX_NONE, 3'd2, 1'b0));
	endtask

	// millisecond scaling, stripping into the fraction
	task automatic test_msec();
		send_request(make_request(32'h0000_0041, 1'b0, fpda_pkg::PFX_NONE,  3'd0, 1'b1));
		send_request(make_request(32'h0000_ffff, 1'b0, fpda_pkg::PFX_NONE,  3'd0, 1'b1));
		send_request(make_request(32'h0002_8000, 1'b0, fpda_pkg::PFX_PLUS,  3'd3, 1'b1));
		send_request(make_request(32'hfffe_0010, 1'b1, fpda_pkg::PFX_NONE,  3'd2, 1'b1));
		send_request(make_request(32'h0000_0000, 1'b0, fpda_pkg::PFX_MINUS, 3'd6, 1'b1));
	endtask

	// random numbers, biased toward rounding edges, small integers and integers near the top
	task automatic test_random_numbers(input int count);
		fpda_pkg::in_item_t req;
		logic [31:0]        value;

		repeat (count) begin
			case ($urandom_range(3))
				0: value = $urandom;
				1: value = {16'($urandom_range(99)), 16'($urandom)};
				2: value = {16'($urandom), 16'hffff - 16'($urandom_range(15))};
				default: value = {16'hffff - 16'($urandom_range(3)), 16'($urandom)};
			endcase
			req = make_request(value, 1'($urandom_range(1)), 2'($urandom_range(3)),
				3'($urandom_range(7)), 1'($urandom_range(1)));
			send_request(req);
		end
	endtask

	// test sequence
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		error_count   = 0;
		send_idle_pct = 29;
		recv_idle_pct = 52;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_sign_prefix();
		test_rounding();
		test_msec();
		test_random_numbers(36);

		send_idle_pct = 52;
		recv_idle_pct = 29;
		test_random_numbers(36);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_numbers(36);
		in_valid <= 1'b0;

		// drain outstanding characters
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
rtl/fpda_pkg.sv
rtl/fpda_ctrl.sv
rtl/fpda_dpath.sv
rtl/fixed_point_to_decimal_ascii.sv
sim/testbench.sv
